// ===== rtl/lrib_pkg.sv =====
`timescale 1ns / 1ps

package lrib_pkg;

  // Fixed field widths.
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned NUM_CHAN  = 4;
  localparam int unsigned INDEX_W   = 12;
  localparam int unsigned BOUND_W   = 13;
  localparam int unsigned WEIGHT_W  = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // The weight quotient is produced two bits per divider stage.
  localparam int unsigned DIV_STEPS  = 2;
  localparam int unsigned DIV_STAGES = WEIGHT_W / DIV_STEPS;

  // Channel slots inside a channel vector.
  localparam int unsigned CH_RED   = 3;
  localparam int unsigned CH_GREEN = 2;
  localparam int unsigned CH_BLUE  = 1;
  localparam int unsigned CH_ALPHA = 0;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION   = 2'd2;

  // Direction register values.
  localparam logic DIR_VERTICAL   = 1'b0;
  localparam logic DIR_HORIZONTAL = 1'b1;

  typedef struct packed {
    logic [CHAN_W-1:0]  first_red;
    logic [CHAN_W-1:0]  first_green;
    logic [CHAN_W-1:0]  first_blue;
    logic [CHAN_W-1:0]  first_alpha;
    logic [CHAN_W-1:0]  second_red;
    logic [CHAN_W-1:0]  second_green;
    logic [CHAN_W-1:0]  second_blue;
    logic [CHAN_W-1:0]  second_alpha;
    logic [INDEX_W-1:0] row_index;
    logic [INDEX_W-1:0] column_index;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_alpha;
  } out_item_t;

  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] chan_vec_t;

  // Pixel pair carried down the pipeline.
  typedef struct packed {
    chan_vec_t first;
    chan_vec_t second;
  } pair_t;

  // Per-stage control: valid bit and the region the position fell into.
  typedef struct packed {
    logic valid;
    logic mix;
    logic sec;
  } ctl_t;

endpackage

// ===== rtl/lrib_decode.sv =====
`timescale 1ns / 1ps

module lrib_decode #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  lrib_pkg::in_item_t                  item_i,
  input  logic [lrib_pkg::BOUND_W-1:0]        start_i,
  input  logic [lrib_pkg::BOUND_W-1:0]        end_i,
  input  logic                                dir_i,
  output lrib_pkg::ctl_t                      ctl_o,
  output lrib_pkg::pair_t                     pair_o,
  output logic [COORD_BITS:0]                 rem_o,
  output logic [COORD_BITS:0]                 div_o
);

  import lrib_pkg::*;

  localparam int unsigned PW = COORD_BITS + 1;
  localparam int unsigned XW = (PW > BOUND_W) ? PW : BOUND_W;
  localparam logic [XW-1:0] LIMIT = XW'(1) << COORD_BITS;

  logic [XW-1:0] start_x, end_x;
  logic [PW-1:0] s_c, e_c, pos;
  ctl_t          ctl_d, ctl_q;
  pair_t         pair_d, pair_q;
  logic [PW-1:0] rem_d, rem_q, div_d, div_q;

  // Saturate the bounds, pick the position and classify it.
  always_comb begin
    start_x = XW'(start_i);
    end_x   = XW'(end_i);
    s_c     = (start_x > LIMIT) ? PW'(LIMIT) : PW'(start_x);
    e_c     = (end_x > LIMIT) ? PW'(LIMIT) : PW'(end_x);
    if (dir_i == DIR_HORIZONTAL) begin
      pos = PW'(COORD_BITS'(item_i.column_index));
    end else begin
      pos = PW'(COORD_BITS'(item_i.row_index));
    end
    ctl_d.valid = valid_i;
    ctl_d.sec   = (pos >= e_c);
    ctl_d.mix   = !ctl_d.sec && (pos >= s_c) && (e_c > s_c);
    rem_d       = pos - s_c;
    div_d       = e_c - s_c;
    pair_d.first  = {item_i.first_red, item_i.first_green,
                     item_i.first_blue, item_i.first_alpha};
    pair_d.second = {item_i.second_red, item_i.second_green,
                     item_i.second_blue, item_i.second_alpha};
  end

  // Control register with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pair_q <= pair_d;
      rem_q  <= rem_d;
      div_q  <= div_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign pair_o = pair_q;
  assign rem_o  = rem_q;
  assign div_o  = div_q;

endmodule

// ===== rtl/lrib_div_stage.sv =====
`timescale 1ns / 1ps

module lrib_div_stage #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  lrib_pkg::ctl_t                      ctl_i,
  input  lrib_pkg::pair_t                     pair_i,
  input  logic [COORD_BITS:0]                 rem_i,
  input  logic [COORD_BITS:0]                 div_i,
  input  logic [lrib_pkg::WEIGHT_W-1:0]       quo_i,
  output lrib_pkg::ctl_t                      ctl_o,
  output lrib_pkg::pair_t                     pair_o,
  output logic [COORD_BITS:0]                 rem_o,
  output logic [COORD_BITS:0]                 div_o,
  output logic [lrib_pkg::WEIGHT_W-1:0]       quo_o
);

  import lrib_pkg::*;

  localparam int unsigned PW = COORD_BITS + 1;

  logic [PW-1:0]       rem_d, rem_q, div_q;
  logic [PW:0]         twice;
  logic [WEIGHT_W-1:0] quo_d, quo_q;
  ctl_t                ctl_q;
  pair_t               pair_q;

  // Restoring division steps: double the remainder, subtract when it fits.
  always_comb begin
    rem_d = rem_i;
    quo_d = quo_i;
    twice = '0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      twice = {rem_d, 1'b0};
      if (twice >= {1'b0, div_i}) begin
        rem_d = PW'(twice - {1'b0, div_i});
        quo_d = {quo_d[WEIGHT_W-2:0], 1'b1};
      end else begin
        rem_d = PW'(twice);
        quo_d = {quo_d[WEIGHT_W-2:0], 1'b0};
      end
    end
  end

  // Control register with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pair_q <= pair_i;
      rem_q  <= rem_d;
      div_q  <= div_i;
      quo_q  <= quo_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign pair_o = pair_q;
  assign rem_o  = rem_q;
  assign div_o  = div_q;
  assign quo_o  = quo_q;

endmodule

// ===== rtl/lrib_mix.sv =====
`timescale 1ns / 1ps

module lrib_mix (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  lrib_pkg::ctl_t                ctl_i,
  input  lrib_pkg::pair_t               pair_i,
  input  logic [lrib_pkg::WEIGHT_W-1:0] quo_i,
  output logic                          valid_o,
  output lrib_pkg::out_item_t           item_o
);

  import lrib_pkg::*;

  localparam int unsigned WW = WEIGHT_W + 1;
  localparam int unsigned DW = CHAN_W + 1;
  localparam int unsigned PRW = WW + 1 + DW;

  logic [WW-1:0]                          weight;
  logic signed [NUM_CHAN-1:0][PRW-1:0]    prod_d, prod_q;
  logic signed [DW-1:0]                   diff;
  chan_vec_t                              first_q;
  logic                                   mul_valid_q;
  logic                                   out_valid_q;
  logic signed [PRW-1:0]                  shifted;
  logic signed [CHAN_W+1:0]               sum;
  chan_vec_t                              res_d;
  out_item_t                              out_q;

  // Weight: the quotient on the ramp, full second pixel at 256, first at 0.
  always_comb begin
    if (ctl_i.mix) begin
      weight = WW'(quo_i);
    end else if (ctl_i.sec) begin
      weight = WW'(1) << WEIGHT_W;
    end else begin
      weight = '0;
    end
    diff = '0;
    for (int c = 0; c < NUM_CHAN; c++) begin
      diff      = $signed({1'b0, pair_i.second[c]}) - $signed({1'b0, pair_i.first[c]});
      prod_d[c] = $signed({1'b0, weight}) * diff;
    end
  end

  // Product stage registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (en_i) begin
      mul_valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod_d;
      first_q <= pair_i.first;
    end
  end

  // Add the floored scaled difference back onto the first pixel.
  always_comb begin
    shifted = '0;
    sum     = '0;
    for (int c = 0; c < NUM_CHAN; c++) begin
      shifted  = prod_q[c] >>> WEIGHT_W;
      sum      = $signed({2'b00, first_q[c]}) + $signed(shifted[CHAN_W+1:0]);
      res_d[c] = sum[CHAN_W-1:0];
    end
  end

  // Output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q.out_red   <= res_d[CH_RED];
      out_q.out_green <= res_d[CH_GREEN];
      out_q.out_blue  <= res_d[CH_BLUE];
      out_q.out_alpha <= res_d[CH_ALPHA];
    end
  end

  assign valid_o = out_valid_q;
  assign item_o  = out_q;

endmodule

// ===== rtl/linear_ramp_image_blend.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                Payload
// in        input      in_valid_i/in_stall_o    in_data_i  (pixel pair, row, column)
// out       output     out_valid_o/out_stall_i  out_data_o (blended pixel)
// cfg       input      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// One pixel pair is accepted per clock while no finished result is held by a
// stalled output. Results pass through seven register stages: the position decode,
// the weight divider with four stages of two quotient bits each, a multiply stage
// and an add stage.
// Reset clears the valid bits and sets all configuration registers to zero.
// A stall on a valid output freezes the whole pipeline; nothing is dropped or repeated.

module linear_ramp_image_blend #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  lrib_pkg::in_item_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output lrib_pkg::out_item_t            out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lrib_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lrib_pkg::BOUND_W-1:0]   cfg_data_i
);

  import lrib_pkg::*;

  localparam int unsigned PW = COORD_BITS + 1;

  logic [BOUND_W-1:0] start_q, end_q;
  logic               dir_q;
  logic               adv;

  ctl_t                ctl   [DIV_STAGES+1];
  pair_t               pair  [DIV_STAGES+1];
  logic [PW-1:0]       rem   [DIV_STAGES+1];
  logic [PW-1:0]       div   [DIV_STAGES+1];
  logic [WEIGHT_W-1:0] quo   [DIV_STAGES+1];

  // The pipeline moves unless a finished result is held by the output.
  assign adv         = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !adv;
  assign cfg_ready_o = 1'b1;

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      end_q   <= '0;
      dir_q   <= DIR_VERTICAL;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_BLEND_START: start_q <= cfg_data_i;
        CFG_BLEND_END:   end_q   <= cfg_data_i;
        CFG_DIRECTION:   dir_q   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Position decode and bound saturation.
  lrib_decode #(
    .COORD_BITS(COORD_BITS)
  ) u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(in_valid_i),
    .item_i (in_data_i),
    .start_i(start_q),
    .end_i  (end_q),
    .dir_i  (dir_q),
    .ctl_o  (ctl[0]),
    .pair_o (pair[0]),
    .rem_o  (rem[0]),
    .div_o  (div[0])
  );

  assign quo[0] = '0;

  // Weight divider pipeline.
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    lrib_div_stage #(
      .COORD_BITS(COORD_BITS)
    ) u_div (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (adv),
      .ctl_i (ctl[g]),
      .pair_i(pair[g]),
      .rem_i (rem[g]),
      .div_i (div[g]),
      .quo_i (quo[g]),
      .ctl_o (ctl[g+1]),
      .pair_o(pair[g+1]),
      .rem_o (rem[g+1]),
      .div_o (div[g+1]),
      .quo_o (quo[g+1])
    );
  end

  // Channel multiply and add.
  lrib_mix u_mix (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .ctl_i  (ctl[DIV_STAGES]),
    .pair_i (pair[DIV_STAGES]),
    .quo_i  (quo[DIV_STAGES]),
    .valid_o(out_valid_o),
    .item_o (out_data_o)
  );

endmodule

// ===== tb/sv/tb_linear_ramp_image_blend.sv =====
`timescale 1ns / 1ps

module tb_linear_ramp_image_blend;
  import lrib_pkg::*;

  // Register index that the block does not decode.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int COORD_SPAN = 4096;
  localparam int CYCLE_LIMIT = 200000;

  // One row of the directed stimulus: ramp settings, pixel pair and an
  // optional hand-written expected pixel.
  typedef struct {
    logic [BOUND_W-1:0] ramp_lo;
    logic [BOUND_W-1:0] ramp_hi;
    logic               horiz;
    in_item_t           pixel;
    bit                 typed;
    out_item_t          want;
  } ramp_case_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  in_item_t             in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  out_item_t            out_data_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [BOUND_W-1:0]   cfg_data_i;

  // Shadow of the block's configuration registers.
  logic [BOUND_W-1:0] cur_lo;
  logic [BOUND_W-1:0] cur_hi;
  logic               cur_horiz;

  out_item_t  blended_queue[$];
  ramp_case_t directed_cases[$];
  int         error_count = 0;
  int         cycle_count = 0;
  bit         idle_on = 1'b1;
  int         long_hold = 0;
  int         stall_left = 0;

  linear_ramp_image_blend dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Computes the crossfaded pixel for one pixel pair under the given ramp.
  function automatic out_item_t ramp_blend(in_item_t px, logic [BOUND_W-1:0] lo_reg,
                                           logic [BOUND_W-1:0] hi_reg, logic horiz);
    int lo;
    int hi;
    int pos;
    int weight;
    logic [3:0][7:0] first_v;
    logic [3:0][7:0] second_v;
    logic [3:0][7:0] mixed;
    lo = (lo_reg > COORD_SPAN) ? COORD_SPAN : int'(lo_reg);
    hi = (hi_reg > COORD_SPAN) ? COORD_SPAN : int'(hi_reg);
    pos = (horiz == DIR_HORIZONTAL) ? int'(px.column_index) : int'(px.row_index);
    first_v = {px.first_red, px.first_green, px.first_blue, px.first_alpha};
    second_v = {px.second_red, px.second_green, px.second_blue, px.second_alpha};
    if (pos >= hi) begin
      mixed = second_v;
    end else if (pos >= lo && hi > lo) begin
      weight = (256 * (pos - lo)) / (hi - lo);
      // The arithmetic shift rounds the scaled difference toward minus infinity.
      for (int k = 0; k < 4; k++) begin
        mixed[k] = 8'(int'(first_v[k]) +
                      ((weight * (int'(second_v[k]) - int'(first_v[k]))) >>> 8));
      end
    end else begin
      mixed = first_v;
    end
    return out_item_t'(mixed);
  endfunction

  // Random pixel pair whose ramp coordinate mostly falls near the ramp.
  function automatic in_item_t random_pixel(logic [BOUND_W-1:0] lo, logic [BOUND_W-1:0] hi,
                                            logic horiz);
    int near_lo;
    int near_hi;
    int pos;
    in_item_t px;
    px = in_item_t'({$urandom, $urandom, 24'($urandom)});
    if ($urandom_range(0, 3) != 0) begin
      near_lo = ((lo < hi) ? int'(lo) : int'(hi)) - 40;
      near_hi = ((lo < hi) ? int'(hi) : int'(lo)) + 40;
      if (near_lo < 0) near_lo = 0;
      if (near_lo > 4095) near_lo = 4095;
      if (near_hi > 4095) near_hi = 4095;
      pos = $urandom_range(near_lo, near_hi);
      if (horiz == DIR_HORIZONTAL) px.column_index = 12'(pos);
      else px.row_index = 12'(pos);
    end
    return px;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic add_case(input logic [BOUND_W-1:0] lo, input logic [BOUND_W-1:0] hi,
                          input logic horiz, input in_item_t px, input bit typed,
                          input out_item_t want);
    ramp_case_t rc;
    rc.ramp_lo = lo;
    rc.ramp_hi = hi;
    rc.horiz = horiz;
    rc.pixel = px;
    rc.typed = typed;
    rc.want = want;
    directed_cases.push_back(rc);
  endtask

  // Issues one register write request and updates the shadow on acceptance.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BOUND_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_BLEND_START: cur_lo = data;
      CFG_BLEND_END:   cur_hi = data;
      CFG_DIRECTION:   cur_horiz = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Stops offering requests and waits until every expected pixel has come back.
  task automatic drain;
    in_valid_i <= 1'b0;
    while (blended_queue.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_ramp(input logic [BOUND_W-1:0] lo, input logic [BOUND_W-1:0] hi,
                          input logic horiz);
    drain();
    write_reg(CFG_BLEND_START, lo);
    write_reg(CFG_BLEND_END, hi);
    write_reg(CFG_DIRECTION, {{(BOUND_W-1){1'b0}}, horiz});
  endtask

  // Offers one pixel pair request; entered and left just after a falling edge.
  task automatic send_pixel(input in_item_t px, input bit typed, input out_item_t want);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= px;
    do @(posedge clk_i); while (in_stall_o);
    blended_queue.push_back(typed ? want : ramp_blend(px, cur_lo, cur_hi, cur_horiz));
    @(negedge clk_i);
  endtask

  task automatic run_random_phase(input int count, input bit idle, input int hold);
    logic [BOUND_W-1:0] lo;
    logic [BOUND_W-1:0] hi;
    case ($urandom_range(0, 4))
      0: begin
        lo = 13'($urandom);
        hi = 13'($urandom);
      end
      1: begin
        lo = 13'($urandom_range(0, 4000));
        hi = lo + 13'($urandom_range(1, 300));
      end
      2: begin
        lo = 13'($urandom_range(0, 4094));
        hi = lo + 13'd1;
      end
      3: begin
        lo = 13'($urandom_range(0, 4095));
        hi = 13'($urandom_range(4096, 8191));
      end
      default: begin
        hi = 13'($urandom_range(0, 4095));
        lo = hi + 13'($urandom_range(0, 200));
      end
    endcase
    set_ramp(lo, hi, 1'($urandom));
    idle_on = idle;
    long_hold = hold;
    repeat (count) send_pixel(random_pixel(cur_lo, cur_hi, cur_horiz), 1'b0, '0);
  endtask

  // Output side: stall count per result, plus a long hold-off when requested.
  initial out_stall_i = 1'b0;

  always @(negedge clk_i) begin
    if (long_hold > 0) begin
      stall_left = long_hold;
      long_hold = 0;
    end
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare every accepted result with the oldest expected pixel.
  always @(posedge clk_i) begin
    logic [3:0][7:0] got_v;
    logic [3:0][7:0] want_v;
    string chan_name[4];
    chan_name = '{"alpha", "blue", "green", "red"};
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (blended_queue.size() == 0) begin
        report_error($sformatf("unexpected result %h", out_data_o));
      end else begin
        got_v = out_data_o;
        want_v = blended_queue.pop_front();
        for (int k = 0; k < 4; k++) begin
          if (got_v[k] !== want_v[k]) begin
            report_error($sformatf("%s got %h expected %h", chan_name[k], got_v[k],
                                   want_v[k]));
          end
        end
      end
      stall_left = idle_on ? $urandom_range(0, 3) : 0;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_BLEND_START;
    cfg_data_i = '0;
    cur_lo = '0;
    cur_hi = '0;
    cur_horiz = DIR_VERTICAL;

    // After reset the ramp is empty at zero, so every pixel takes the second image.
    add_case(0, 0, DIR_VERTICAL, {32'h11223344, 32'hAABBCCDD, 12'd0, 12'd0}, 1,
             32'hAABBCCDD);
    add_case(0, 0, DIR_VERTICAL, {32'hFFFFFFFF, 32'h0, 12'd4095, 12'd4095}, 1, 32'h0);
    // Vertical ramp: below, at the start, inside and at the end of the ramp.
    add_case(100, 200, DIR_VERTICAL, {32'h11223344, 32'hAABBCCDD, 12'd99, 12'd4095}, 1,
             32'h11223344);
    add_case(100, 200, DIR_VERTICAL, {32'h11223344, 32'hAABBCCDD, 12'd100, 12'd0}, 1,
             32'h11223344);
    add_case(100, 200, DIR_VERTICAL, {32'h11223344, 32'hAABBCCDD, 12'd150, 12'd7}, 0, '0);
    add_case(100, 200, DIR_VERTICAL, {32'hFFFFFFFF, 32'h0, 12'd199, 12'd0}, 0, '0);
    add_case(100, 200, DIR_VERTICAL, {32'h0, 32'hFFFFFFFF, 12'd199, 12'd4095}, 0, '0);
    add_case(100, 200, DIR_VERTICAL, {32'h11223344, 32'hAABBCCDD, 12'd200, 12'd0}, 1,
             32'hAABBCCDD);
    // Horizontal ramp over the whole coordinate range.
    add_case(0, 4096, DIR_HORIZONTAL, {32'h0, 32'hFFFFFFFF, 12'd4095, 12'd0}, 1, 32'h0);
    add_case(0, 4096, DIR_HORIZONTAL, {32'h0, 32'hFFFFFFFF, 12'd0, 12'd4095}, 0, '0);
    add_case(0, 4096, DIR_HORIZONTAL, {32'hFFFFFFFF, 32'h0, 12'd0, 12'd4095}, 0, '0);
    // Bounds past the coordinate range saturate.
    add_case(8191, 8191, DIR_HORIZONTAL, {32'h0, 32'hFFFFFFFF, 12'd0, 12'd2048}, 1, 32'h0);
    add_case(0, 8191, DIR_HORIZONTAL, {32'h0, 32'hFFFFFFFF, 12'd0, 12'd2048}, 0, '0);
    add_case(4096, 4096, DIR_VERTICAL, {32'h11223344, 32'hAABBCCDD, 12'd4095, 12'd0}, 1,
             32'h11223344);
    // Inverted ramp: the end bound alone decides.
    add_case(300, 100, DIR_HORIZONTAL, {32'h11223344, 32'hAABBCCDD, 12'd0, 12'd50}, 1,
             32'h11223344);
    add_case(300, 100, DIR_HORIZONTAL, {32'h11223344, 32'hAABBCCDD, 12'd0, 12'd100}, 1,
             32'hAABBCCDD);
    add_case(300, 100, DIR_HORIZONTAL, {32'h11223344, 32'hAABBCCDD, 12'd4095, 12'd200}, 1,
             32'hAABBCCDD);
    // Empty ramp.
    add_case(500, 500, DIR_HORIZONTAL, {32'h11223344, 32'hAABBCCDD, 12'd0, 12'd499}, 1,
             32'h11223344);
    add_case(500, 500, DIR_HORIZONTAL, {32'h11223344, 32'hAABBCCDD, 12'd0, 12'd500}, 1,
             32'hAABBCCDD);
    // Rounding of negative and positive scaled differences.
    add_case(0, 256, DIR_VERTICAL, {32'hFFFFFFFF, 32'h0, 12'd1, 12'd0}, 0, '0);
    add_case(0, 256, DIR_VERTICAL, {32'h0, 32'hFFFFFFFF, 12'd1, 12'd0}, 0, '0);
    add_case(0, 256, DIR_VERTICAL, {32'h80808080, 32'h7F7F7F7F, 12'd255, 12'd0}, 0, '0);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows; the ramp is rewritten only when a row asks for new settings.
    foreach (directed_cases[i]) begin
      if (directed_cases[i].ramp_lo != cur_lo || directed_cases[i].ramp_hi != cur_hi ||
          directed_cases[i].horiz != cur_horiz) begin
        set_ramp(directed_cases[i].ramp_lo, directed_cases[i].ramp_hi,
                 directed_cases[i].horiz);
      end
      send_pixel(directed_cases[i].pixel, directed_cases[i].typed, directed_cases[i].want);
    end

    // A write to the undecoded index must leave the ramp untouched.
    drain();
    write_reg(CFG_UNUSED, '1);
    repeat (8) send_pixel(random_pixel(cur_lo, cur_hi, cur_horiz), 1'b0, '0);

    // Random phases: two without idling, one of them with a long output hold-off.
    for (int ph = 0; ph < 10; ph++) begin
      run_random_phase(64, !(ph == 3 || ph == 6), (ph == 6) ? 60 : 0);
    end

    in_valid_i <= 1'b0;
    while (blended_queue.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lrib_pkg.sv
rtl/lrib_decode.sv
rtl/lrib_div_stage.sv
rtl/lrib_mix.sv
rtl/linear_ramp_image_blend.sv
tb/sv/tb_linear_ramp_image_blend.sv
